[rtl/core/crsf_pkg.sv]
// Shared types, codes and the CRC-8 step function of the frame receiver.
`timescale 1ns / 1ps

package crsf_pkg;

   localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
   localparam logic [7:0] TYPE_LINK_STATS  = 8'h14;
   localparam logic [7:0] CRC_POLY         = 8'hD5;
   localparam logic [7:0] MIN_LENGTH       = 8'd2;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_LINK    = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [7:0] CSR_SYNC_ADDRESS   = 8'd0;
   localparam logic [7:0] CSR_FAILSAFE_TICKS = 8'd1;

   localparam logic [7:0]  SYNC_ADDRESS_RESET   = 8'hC8;
   localparam logic [15:0] FAILSAFE_TICKS_RESET = 16'd200;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   typedef enum logic [1:0] {
      PH_SYNC,
      PH_LENGTH,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LOAD,
      BK_UNPACK
   } back_state_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        channel_index;
      logic [10:0]       channel_value;
      logic [7:0]        uplink_rssi;
      logic [7:0]        link_quality;
      logic signed [7:0] snr;
      logic              link_ok;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] uplink_rssi;
      logic [7:0] link_quality;
      logic [7:0] snr;
      logic       link_ok;
   } cmd_type;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/core/crsf_frame_receiver.sv]
// Top level of the serial frame receiver: control registers and the parser, queue and sequencer.
//
//  Channel   Ports                              Request accepted when
//  input     req_push, req_data, req_full       req_push high and req_full low
//  result    rsp_pop, rsp_data, rsp_empty       rsp_pop high and rsp_empty low
//  control   csr_valid, csr_ready, csr_index,   csr_valid and csr_ready high
//            csr_data
//
// A byte or tick request is taken whenever req_full is low.
// After a good channel frame the input stays full until the unpacker has sent the
// last channel, since the unpacker walks the single read port of the frame store
// one byte at a time.
// The command queue holds four frame or tick commands; a stalled result port fills it.
// Reset is synchronous and clears parser, link age, queue, sequencer state and the result valid flag.
`timescale 1ns / 1ps

module crsf_frame_receiver #(
   parameter int FRAME_BYTES   = 64,
   parameter int CHANNEL_COUNT = 16,
   parameter int CHANNEL_WIDTH = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  crsf_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output crsf_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int POS_W = $clog2(FRAME_BYTES);

   logic [7:0]        sync_address_ff;
   logic [15:0]       failsafe_ticks_ff;
   logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
   crsf_pkg::cmd_type cmd_data, cmd_head;
   logic              rc_done, rd_en;
   logic [POS_W-1:0]  rd_addr;
   logic [7:0]        rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_address_ff   <= crsf_pkg::SYNC_ADDRESS_RESET;
         failsafe_ticks_ff <= crsf_pkg::FAILSAFE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == crsf_pkg::CSR_SYNC_ADDRESS) begin
            sync_address_ff <= csr_data[7:0];
         end else if (csr_index == crsf_pkg::CSR_FAILSAFE_TICKS) begin
            failsafe_ticks_ff <= csr_data;
         end
      end
   end

   crsf_front #(
      .FRAME_BYTES   (FRAME_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .CHANNEL_WIDTH (CHANNEL_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .sync_address   (sync_address_ff),
      .failsafe_ticks (failsafe_ticks_ff),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data),
      .cmd_full       (cmd_full),
      .rc_done        (rc_done),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   crsf_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   crsf_back #(
      .FRAME_BYTES   (FRAME_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .CHANNEL_WIDTH (CHANNEL_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rc_done   (rc_done),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

[rtl/core/crsf_cmd_fifo.sv]
// Short command queue between the frame parser and the result sequencer.
`timescale 1ns / 1ps

module crsf_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  crsf_pkg::cmd_type push_data,
   input  logic              pop,
   output crsf_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   crsf_pkg::cmd_type                 entries_ff [crsf_pkg::CMD_DEPTH];
   logic [crsf_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [crsf_pkg::CMD_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [crsf_pkg::CMD_PTR_W:0]      count_ff, count_in;
   logic                              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (crsf_pkg::CMD_PTR_W + 1)'(crsf_pkg::CMD_DEPTH));
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == crsf_pkg::CMD_PTR_W'(crsf_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == crsf_pkg::CMD_PTR_W'(crsf_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/crsf_front.sv]
// Frame parser: sync hunt, length check, frame store, CRC-8 and link age tracking.
`timescale 1ns / 1ps

module crsf_front #(
   parameter int FRAME_BYTES   = 64,
   parameter int CHANNEL_COUNT = 16,
   parameter int CHANNEL_WIDTH = 11,
   localparam int POS_W        = $clog2(FRAME_BYTES),
   localparam int LEN_W        = $clog2(FRAME_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  crsf_pkg::req_type req_data,
   output logic              req_full,
   input  logic [7:0]        sync_address,
   input  logic [15:0]       failsafe_ticks,
   output logic              cmd_push,
   output crsf_pkg::cmd_type cmd_data,
   input  logic              cmd_full,
   input  logic              rc_done,
   input  logic              rd_en,
   input  logic [POS_W-1:0]  rd_addr,
   output logic [7:0]        rd_data
);

   localparam int RC_PAYLOAD = (CHANNEL_COUNT * CHANNEL_WIDTH + 7) / 8;
   localparam logic [LEN_W-1:0] RC_MIN_LEN   = LEN_W'(RC_PAYLOAD + 3);
   localparam logic [LEN_W-1:0] LINK_MIN_LEN = LEN_W'(7);
   localparam logic [7:0]       MAX_LENGTH   = 8'(FRAME_BYTES - 2);

   logic [7:0] store [FRAME_BYTES];
   logic [7:0] rd_data_ff;

   crsf_pkg::phase_type phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [7:0]          crc_ff, crc_in;
   logic                seen_ff, seen_in;
   logic [15:0]         age_ff, age_in;
   logic                lock_ff, lock_in;
   logic [7:0]          ftype_ff, ftype_in;
   logic [7:0]          rssi_ff, rssi_in;
   logic [7:0]          lq_ff, lq_in;
   logic [7:0]          snr_ff, snr_in;

   logic                accept;
   logic [7:0]          rx;
   logic                store_we;
   logic [POS_W-1:0]    store_addr;
   logic                frame_end;

   assign req_full  = lock_ff || cmd_full;
   assign accept    = req_push && !req_full;
   assign rx        = req_data.rx_byte;
   assign rd_data   = rd_data_ff;
   assign frame_end = (LEN_W'(pos_ff) + LEN_W'(1)) >= len_ff;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      seen_in    = seen_ff;
      age_in     = age_ff;
      lock_in    = lock_ff && !rc_done;
      ftype_in   = ftype_ff;
      rssi_in    = rssi_ff;
      lq_in      = lq_ff;
      snr_in     = snr_ff;
      store_we   = 1'b0;
      store_addr = '0;
      cmd_push   = 1'b0;
      cmd_data   = '0;
      if (accept) begin
         if (req_data.mode) begin
            age_in            = (age_ff != 16'hFFFF) ? age_ff + 16'd1 : age_ff;
            cmd_push          = 1'b1;
            cmd_data.kind     = crsf_pkg::KIND_STATUS;
            cmd_data.link_ok  = seen_ff && (age_in <= failsafe_ticks);
         end else begin
            unique case (phase_ff)
               crsf_pkg::PH_LENGTH: begin
                  if (rx < crsf_pkg::MIN_LENGTH || rx > MAX_LENGTH) begin
                     phase_in = crsf_pkg::PH_SYNC;
                     pos_in   = '0;
                  end else begin
                     store_we   = 1'b1;
                     store_addr = POS_W'(1);
                     len_in     = LEN_W'(rx) + LEN_W'(2);
                     pos_in     = POS_W'(2);
                     crc_in     = '0;
                     phase_in   = crsf_pkg::PH_DATA;
                  end
               end
               crsf_pkg::PH_DATA: begin
                  store_we   = 1'b1;
                  store_addr = pos_ff;
                  if (pos_ff == POS_W'(2)) ftype_in = rx;
                  if (pos_ff == POS_W'(3)) rssi_in = rx;
                  if (pos_ff == POS_W'(5)) lq_in = rx;
                  if (pos_ff == POS_W'(6)) snr_in = rx;
                  if (frame_end) begin
                     phase_in = crsf_pkg::PH_SYNC;
                     pos_in   = '0;
                     if (rx == crc_ff) begin
                        if (ftype_in == crsf_pkg::TYPE_RC_CHANNELS && len_ff >= RC_MIN_LEN) begin
                           seen_in          = 1'b1;
                           age_in           = '0;
                           lock_in          = 1'b1;
                           cmd_push         = 1'b1;
                           cmd_data.kind    = crsf_pkg::KIND_CHANNEL;
                           cmd_data.link_ok = 1'b1;
                        end else if (ftype_in == crsf_pkg::TYPE_LINK_STATS &&
                                     len_ff >= LINK_MIN_LEN) begin
                           cmd_push              = 1'b1;
                           cmd_data.kind         = crsf_pkg::KIND_LINK;
                           cmd_data.uplink_rssi  = rssi_in;
                           cmd_data.link_quality = lq_in;
                           cmd_data.snr          = snr_in;
                           cmd_data.link_ok      = seen_ff && (age_ff <= failsafe_ticks);
                        end
                     end
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     crc_in = crsf_pkg::crc8_next(crc_ff, rx);
                  end
               end
               default: begin
                  phase_in = crsf_pkg::PH_SYNC;
                  pos_in   = '0;
                  if (rx == sync_address) begin
                     store_we   = 1'b1;
                     store_addr = '0;
                     pos_in     = POS_W'(1);
                     phase_in   = crsf_pkg::PH_LENGTH;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crsf_pkg::PH_SYNC;
         pos_ff   <= '0;
         len_ff   <= '0;
         crc_ff   <= '0;
         seen_ff  <= 1'b0;
         age_ff   <= '0;
         lock_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         seen_ff  <= seen_in;
         age_ff   <= age_in;
         lock_ff  <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      ftype_ff <= ftype_in;
      rssi_ff  <= rssi_in;
      lq_ff    <= lq_in;
      snr_ff   <= snr_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[store_addr] <= rx;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

endmodule

[rtl/core/crsf_back.sv]
// Result sequencer: unpacks channel frames from the store and drives the result register.
`timescale 1ns / 1ps

module crsf_back #(
   parameter int FRAME_BYTES   = 64,
   parameter int CHANNEL_COUNT = 16,
   parameter int CHANNEL_WIDTH = 11,
   localparam int POS_W        = $clog2(FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  crsf_pkg::cmd_type cmd_head,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              rc_done,
   output logic              rd_en,
   output logic [POS_W-1:0]  rd_addr,
   input  logic [7:0]        rd_data,
   output crsf_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   localparam int BUF_W = CHANNEL_WIDTH + 8;
   localparam int CNT_W = $clog2(CHANNEL_WIDTH + 8);
   localparam logic [BUF_W-1:0] CH_MASK = BUF_W'((1 << CHANNEL_WIDTH) - 1);

   crsf_pkg::back_state_type state_ff, state_in;
   logic [BUF_W-1:0]         bits_ff, bits_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [POS_W-1:0]         ptr_ff, ptr_in;
   logic [3:0]               ch_ff, ch_in;
   logic                     rc_link_ff, rc_link_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   crsf_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     out_free;
   logic [BUF_W-1:0]         masked;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign masked    = bits_ff & CH_MASK;

   always_comb begin
      state_in     = state_ff;
      bits_in      = bits_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      ch_in        = ch_ff;
      rc_link_in   = rc_link_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      rc_done      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      unique case (state_ff)
         crsf_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_head.kind == crsf_pkg::KIND_CHANNEL) begin
                  cmd_pop    = 1'b1;
                  bits_in    = '0;
                  cnt_in     = '0;
                  ptr_in     = POS_W'(3);
                  ch_in      = '0;
                  rc_link_in = cmd_head.link_ok;
                  state_in   = crsf_pkg::BK_FETCH;
               end else if (out_free) begin
                  cmd_pop              = 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_in               = '0;
                  rsp_in.kind          = cmd_head.kind;
                  rsp_in.link_ok       = cmd_head.link_ok;
                  rsp_in.last          = 1'b1;
                  if (cmd_head.kind == crsf_pkg::KIND_LINK) begin
                     rsp_in.uplink_rssi  = cmd_head.uplink_rssi;
                     rsp_in.link_quality = cmd_head.link_quality;
                     rsp_in.snr          = $signed(cmd_head.snr);
                  end
               end
            end
         end
         crsf_pkg::BK_FETCH: begin
            rd_en    = 1'b1;
            state_in = crsf_pkg::BK_LOAD;
         end
         crsf_pkg::BK_LOAD: begin
            bits_in  = bits_ff | (BUF_W'(rd_data) << cnt_ff);
            cnt_in   = cnt_ff + CNT_W'(8);
            ptr_in   = ptr_ff + 1'b1;
            state_in = crsf_pkg::BK_UNPACK;
         end
         crsf_pkg::BK_UNPACK: begin
            if (cnt_ff >= CNT_W'(CHANNEL_WIDTH)) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in               = '0;
                  rsp_in.kind          = crsf_pkg::KIND_CHANNEL;
                  rsp_in.channel_index = ch_ff;
                  rsp_in.channel_value = masked[10:0];
                  rsp_in.link_ok       = rc_link_ff;
                  rsp_in.last          = (ch_ff == 4'(CHANNEL_COUNT - 1));
                  bits_in              = bits_ff >> CHANNEL_WIDTH;
                  cnt_in               = cnt_ff - CNT_W'(CHANNEL_WIDTH);
                  ch_in                = ch_ff + 4'd1;
                  if (ch_ff == 4'(CHANNEL_COUNT - 1)) begin
                     rc_done  = 1'b1;
                     state_in = crsf_pkg::BK_IDLE;
                  end
               end
            end else begin
               state_in = crsf_pkg::BK_FETCH;
            end
         end
         default: begin
            state_in = crsf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crsf_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff    <= bits_in;
      cnt_ff     <= cnt_in;
      ptr_ff     <= ptr_in;
      ch_ff      <= ch_in;
      rc_link_ff <= rc_link_in;
      rsp_ff     <= rsp_in;
   end

endmodule
